/* sv/mmta_pkg.sv */
package mmta_pkg;

  // Largest matrix dimension supported by default
  localparam int unsigned MaxDimDefault = 8;

  // Field widths fixed by the stream format
  localparam int unsigned OpW     = 2;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned ElemW   = 16;
  localparam int unsigned AccW    = 40;
  localparam int unsigned ProdW   = 2 * ElemW;
  localparam int unsigned CountW  = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 4;

  // Stream bus widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned SDataW  = 64;
  localparam int unsigned MDataW  = 48;

  typedef enum logic [OpW-1:0] {
    OP_LOAD_A   = 2'd0,
    OP_LOAD_B   = 2'd1,
    OP_LOAD_ACC = 2'd2,
    OP_RUN      = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_A_ROWS  = 3'd0,
    CFG_A_COLS  = 3'd1,
    CFG_B_ROWS  = 3'd2,
    CFG_B_COLS  = 3'd3,
    CFG_TRANS_A = 3'd4,
    CFG_TRANS_B = 3'd5,
    CFG_CLEAR   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CountW-1:0] a_rows;
    logic [CountW-1:0] a_cols;
    logic [CountW-1:0] b_rows;
    logic [CountW-1:0] b_cols;
    logic              trans_a;
    logic              trans_b;
    logic              clear;
  } cfg_t;

  // Sequencer to MAC datapath
  typedef struct packed {
    logic issue;  // operand reads issued this cycle
    logic init;   // load accumulator start value
    logic clear;  // start value is zero instead of the stored entry
  } mac_ctrl_t;

endpackage

/* sv/mmta_ram.sv */
module mmta_ram
  import mmta_pkg::*;
#(
  parameter int unsigned Width = ElemW,
  parameter int unsigned Depth = MaxDimDefault * MaxDimDefault,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/mmta_mac.sv */
module mmta_mac
  import mmta_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  input  logic signed [ElemW-1:0] a_i,
  input  logic signed [ElemW-1:0] b_i,
  input  logic signed [AccW-1:0]  acc_init_i,
  output logic signed [AccW-1:0]  acc_o,
  output logic                    busy_o
);

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  logic                    rd_vld_q;
  logic                    prod_vld_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  acc_d;
  logic signed [AccW:0]    sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= ctrl_i.issue;
      prod_vld_q <= rd_vld_q;
    end
  end

  // Register the product before the accumulate
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= a_i * b_i;
    end
  end

  // Saturate after every single addition
  always_comb begin
    sum   = (AccW+1)'(acc_q) + (AccW+1)'(prod_q);
    acc_d = acc_q;
    if (ctrl_i.init) begin
      acc_d = ctrl_i.clear ? '0 : acc_init_i;
    end else if (prod_vld_q) begin
      if (sum[AccW] != sum[AccW-1]) begin
        acc_d = sum[AccW] ? AccMin : AccMax;
      end else begin
        acc_d = sum[AccW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = rd_vld_q | prod_vld_q;

endmodule

/* sv/mmta_ctrl.sv */
module mmta_ctrl
  import mmta_pkg::*;
#(
  parameter int unsigned MAX_DIM = MaxDimDefault,
  localparam int unsigned Depth = MAX_DIM * MAX_DIM,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   run_i,
  output logic                   in_ready_o,
  output logic [AddrW-1:0]       a_raddr_o,
  output logic [AddrW-1:0]       b_raddr_o,
  output logic [AddrW-1:0]       acc_raddr_o,
  output mac_ctrl_t              mac_o,
  input  logic                   mac_busy_i,
  input  logic signed [AccW-1:0] acc_i,
  output logic                   wb_we_o,
  output logic [AddrW-1:0]       wb_addr_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [AccW-1:0]        out_value_o,
  output logic [IdxW-1:0]        out_index_o,
  output logic                   out_last_o,
  output logic                   out_err_o
);

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  localparam int unsigned PW   = 2 * DimW + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INIT = 5'b00010,
    S_MAC  = 5'b00100,
    S_DONE = 5'b01000,
    S_ERR  = 5'b10000
  } state_e;

  function automatic logic [DimW-1:0] clamp_dim(input logic [CountW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > CountW'(MAX_DIM)) begin
      r = DimW'(MAX_DIM);
    end else begin
      r = v[DimW-1:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [DimW-1:0]  rows_q, rows_d, inner_q, inner_d, cols_q, cols_d;
  logic [DimW-1:0]  ac_q, ac_d, bc_q, bc_d;
  logic             ta_q, ta_d, tb_q, tb_d, clr_q, clr_d;
  logic [DimW-1:0]  i_q, i_d, k_q, k_d, j_q, j_d;
  logic [AddrW-1:0] o_q, o_d;

  logic [DimW-1:0]  ar, acl, br, bcl, rows_n, inner_a, inner_b, cols_n;
  logic [PW-1:0]    a_w, b_w;
  logic             issue, slot_free, last_elem;

  logic             vld_q, vld_d;
  logic [AccW-1:0]  val_q, val_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             last_q, last_d, err_q, err_d;

  always_comb begin
    ar      = clamp_dim(cfg_i.a_rows);
    acl     = clamp_dim(cfg_i.a_cols);
    br      = clamp_dim(cfg_i.b_rows);
    bcl     = clamp_dim(cfg_i.b_cols);
    rows_n  = cfg_i.trans_a ? acl : ar;
    inner_a = cfg_i.trans_a ? ar : acl;
    inner_b = cfg_i.trans_b ? bcl : br;
    cols_n  = cfg_i.trans_b ? br : bcl;
  end

  // Row-major operand addresses, with the transposes applied
  always_comb begin
    a_w = ta_q ? (PW'(j_q) * PW'(ac_q) + PW'(i_q)) : (PW'(i_q) * PW'(ac_q) + PW'(j_q));
    b_w = tb_q ? (PW'(k_q) * PW'(bc_q) + PW'(j_q)) : (PW'(j_q) * PW'(bc_q) + PW'(k_q));
  end

  assign a_raddr_o   = a_w[AddrW-1:0];
  assign b_raddr_o   = b_w[AddrW-1:0];
  assign acc_raddr_o = o_q;
  assign wb_addr_o   = o_q;

  assign issue      = (state_q == S_MAC) && (j_q != inner_q);
  assign slot_free  = !vld_q || out_ready_i;
  assign last_elem  = (i_q == rows_q - DimW'(1)) && (k_q == cols_q - DimW'(1));
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    mac_o.issue = issue;
    mac_o.init  = (state_q == S_MAC) && (j_q == '0);
    mac_o.clear = clr_q;
  end

  always_comb begin
    state_d = state_q;
    rows_d  = rows_q;
    inner_d = inner_q;
    cols_d  = cols_q;
    ac_d    = ac_q;
    bc_d    = bc_q;
    ta_d    = ta_q;
    tb_d    = tb_q;
    clr_d   = clr_q;
    i_d     = i_q;
    k_d     = k_q;
    j_d     = j_q;
    o_d     = o_q;
    wb_we_o = 1'b0;
    vld_d   = vld_q;
    val_d   = val_q;
    idx_d   = idx_q;
    last_d  = last_q;
    err_d   = err_q;

    if (vld_q && out_ready_i) begin
      vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (run_i) begin
          rows_d  = rows_n;
          inner_d = inner_a;
          cols_d  = cols_n;
          ac_d    = acl;
          bc_d    = bcl;
          ta_d    = cfg_i.trans_a;
          tb_d    = cfg_i.trans_b;
          clr_d   = cfg_i.clear;
          i_d     = '0;
          k_d     = '0;
          o_d     = '0;
          state_d = (inner_a != inner_b) ? S_ERR : S_INIT;
        end
      end
      S_INIT: begin
        j_d     = '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        if (issue) begin
          j_d = j_q + DimW'(1);
        end else if (!mac_busy_i) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          wb_we_o = 1'b1;
          vld_d   = 1'b1;
          val_d   = acc_i;
          idx_d   = o_q;
          last_d  = last_elem;
          err_d   = 1'b0;
          o_d     = o_q + AddrW'(1);
          if (k_q == cols_q - DimW'(1)) begin
            k_d = '0;
            i_d = i_q + DimW'(1);
          end else begin
            k_d = k_q + DimW'(1);
          end
          state_d = last_elem ? S_IDLE : S_INIT;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          vld_d   = 1'b1;
          val_d   = '0;
          idx_d   = '0;
          last_d  = 1'b1;
          err_d   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rows_q  <= rows_d;
    inner_q <= inner_d;
    cols_q  <= cols_d;
    ac_q    <= ac_d;
    bc_q    <= bc_d;
    ta_q    <= ta_d;
    tb_q    <= tb_d;
    clr_q   <= clr_d;
    i_q     <= i_d;
    k_q     <= k_d;
    j_q     <= j_d;
    o_q     <= o_d;
    val_q   <= val_d;
    idx_q   <= idx_d;
    last_q  <= last_d;
    err_q   <= err_d;
  end

  assign out_valid_o = vld_q;
  assign out_value_o = val_q;
  assign out_index_o = IdxW'(idx_q);
  assign out_last_o  = last_q;
  assign out_err_o   = err_q;

endmodule

/* sv/matrix_multiply_transpose_accumulate.sv */
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+------------------------------------------
// s_axis   | in        | tvalid / tready       | tuser: op; tdata: index, value, acc value
// m_axis   | out       | tvalid / tready       | tdata: value, index; tlast; tuser: error
// cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// The block accepts loads only while idle, and a load leaves it idle and ready.
// A run computes each element on the single shared multiply-accumulate unit,
// reading one A and one B entry per cycle. A dimension mismatch sends the sequencer
// to its error state, which gives the single error result once the output is free.
// Reset clears control and configuration; the three stores hold garbage until loaded.
// A stalled output holds the sequencer before the write-back of the next element.
module matrix_multiply_transpose_accumulate
  import mmta_pkg::*;
#(
  parameter int unsigned MAX_DIM = MaxDimDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [SDataW-1:0]  s_axis_tdata_i,  // elem_index[5:0], elem_value[21:6],
                                              // acc_value[61:22], zero pad
  input  logic [OpW-1:0]     s_axis_tuser_i,  // op[1:0]
  // Result stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [MDataW-1:0]  m_axis_tdata_o,  // out_value[39:0], out_index[45:40], zero pad
  output logic               m_axis_tlast_o,  // is_last
  output logic               m_axis_tuser_o,  // dim_error
  // Configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);

  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // Unpack the input transaction
  logic [IdxW-1:0]         elem_index;
  logic signed [ElemW-1:0] elem_value;
  logic signed [AccW-1:0]  acc_value;
  op_e                     op;

  assign elem_index = s_axis_tdata_i[IdxW-1:0];
  assign elem_value = s_axis_tdata_i[IdxW +: ElemW];
  assign acc_value  = s_axis_tdata_i[IdxW+ElemW +: AccW];
  assign op         = op_e'(s_axis_tuser_i);

  logic in_fire, in_range, run;
  logic we_a, we_b, we_acc_load;

  assign in_fire     = s_axis_tvalid_i && s_axis_tready_o;
  // Drop loads that point past the end of the stores
  assign in_range    = {1'b0, elem_index} < (IdxW+1)'(Depth);
  assign we_a        = in_fire && (op == OP_LOAD_A) && in_range;
  assign we_b        = in_fire && (op == OP_LOAD_B) && in_range;
  assign we_acc_load = in_fire && (op == OP_LOAD_ACC) && in_range;
  assign run         = in_fire && (op == OP_RUN);

  // Configuration registers
  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_A_ROWS:  cfg_d.a_rows  = cfg_data_i;
        CFG_A_COLS:  cfg_d.a_cols  = cfg_data_i;
        CFG_B_ROWS:  cfg_d.b_rows  = cfg_data_i;
        CFG_B_COLS:  cfg_d.b_cols  = cfg_data_i;
        CFG_TRANS_A: cfg_d.trans_a = cfg_data_i[0];
        CFG_TRANS_B: cfg_d.trans_b = cfg_data_i[0];
        CFG_CLEAR:   cfg_d.clear   = cfg_data_i[0];
        default: begin
          // Drop writes to unmapped indexes
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_rows  <= CountW'(1);
      cfg_q.a_cols  <= CountW'(1);
      cfg_q.b_rows  <= CountW'(1);
      cfg_q.b_cols  <= CountW'(1);
      cfg_q.trans_a <= 1'b0;
      cfg_q.trans_b <= 1'b0;
      cfg_q.clear   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Sequencer, MAC and stores
  logic [AddrW-1:0]        a_raddr, b_raddr, acc_raddr, wb_addr;
  logic signed [ElemW-1:0] a_rd, b_rd;
  logic signed [AccW-1:0]  acc_rd, acc_cur;
  logic                    wb_we, mac_busy;
  mac_ctrl_t               mac_ctrl;

  logic                    acc_we;
  logic [AddrW-1:0]        acc_waddr;
  logic [AccW-1:0]         acc_wdata;

  logic [AccW-1:0]         out_value;
  logic [IdxW-1:0]         out_index;

  // Loads and write-back never coincide: loads come in only while idle
  assign acc_we    = we_acc_load || wb_we;
  assign acc_waddr = wb_we ? wb_addr : elem_index[AddrW-1:0];
  assign acc_wdata = wb_we ? acc_cur : acc_value;

  mmta_ram #(
    .Width (ElemW),
    .Depth (Depth)
  ) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (elem_index[AddrW-1:0]),
    .wdata_i (elem_value),
    .raddr_i (a_raddr),
    .rdata_o (a_rd)
  );

  mmta_ram #(
    .Width (ElemW),
    .Depth (Depth)
  ) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (elem_index[AddrW-1:0]),
    .wdata_i (elem_value),
    .raddr_i (b_raddr),
    .rdata_o (b_rd)
  );

  mmta_ram #(
    .Width (AccW),
    .Depth (Depth)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rd)
  );

  mmta_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .a_i        (a_rd),
    .b_i        (b_rd),
    .acc_init_i (acc_rd),
    .acc_o      (acc_cur),
    .busy_o     (mac_busy)
  );

  mmta_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .run_i       (run),
    .in_ready_o  (s_axis_tready_o),
    .a_raddr_o   (a_raddr),
    .b_raddr_o   (b_raddr),
    .acc_raddr_o (acc_raddr),
    .mac_o       (mac_ctrl),
    .mac_busy_i  (mac_busy),
    .acc_i       (acc_cur),
    .wb_we_o     (wb_we),
    .wb_addr_o   (wb_addr),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_value_o (out_value),
    .out_index_o (out_index),
    .out_last_o  (m_axis_tlast_o),
    .out_err_o   (m_axis_tuser_o)
  );

  // Pack the result transaction
  assign m_axis_tdata_o = {(MDataW-AccW-IdxW)'(0), out_index, out_value};

endmodule

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mmta_pkg::*;

  // Store depth and accumulator limits of the Q24.16 datapath
  localparam int unsigned Depth        = MaxDimDefault * MaxDimDefault;
  localparam longint      AccMax       = 64'sd549755813887;
  localparam longint      AccMin       = -AccMax - 1;
  // Cycles to let pass once the last result is in, before touching config
  localparam int unsigned SettleCycles = 16;
  // Longest stretch with no transaction on any channel before the bench gives up
  localparam int unsigned WatchLimit   = 4000;

  // One output element of a product, or the single error element
  typedef struct {
    logic [AccW-1:0] value;
    logic [IdxW-1:0] index;
    logic            last;
    logic            err;
  } elem_t;

  // Predicts the GEMM engine: keeps its own registers and stores, computes
  // every output element on run, and compares the block's output in order.
  class gemm_predictor;
    logic [CountW-1:0]       a_rows = 1, a_cols = 1, b_rows = 1, b_cols = 1;
    bit                      trans_a = 0, trans_b = 0, clear_acc = 1;
    logic signed [ElemW-1:0] a_mem   [Depth];
    logic signed [ElemW-1:0] b_mem   [Depth];
    logic signed [AccW-1:0]  acc_mem [Depth];
    bit                      a_set   [Depth];
    bit                      b_set   [Depth];
    bit                      acc_set [Depth];
    elem_t                   pending_elems [$];
    int unsigned             failures = 0;

    function int unsigned clamp(logic [CountW-1:0] v);
      if (v == 0) return 1;
      if (v > MaxDimDefault) return MaxDimDefault;
      return v;
    endfunction

    function longint clip_acc(longint v);
      if (v > AccMax) return AccMax;
      if (v < AccMin) return AccMin;
      return v;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CfgDatW-1:0] data);
      case (idx)
        CFG_A_ROWS:  a_rows = data;
        CFG_A_COLS:  a_cols = data;
        CFG_B_ROWS:  b_rows = data;
        CFG_B_COLS:  b_cols = data;
        CFG_TRANS_A: trans_a = data[0];
        CFG_TRANS_B: trans_b = data[0];
        CFG_CLEAR:   clear_acc = data[0];
        default: ;
      endcase
    endfunction

    // Shape of op(A) * op(B) under the current registers
    function void shape(output int unsigned rows, output int unsigned inner_a,
                        output int unsigned inner_b, output int unsigned cols);
      int unsigned ar, ac, br, bc;
      ar = clamp(a_rows);
      ac = clamp(a_cols);
      br = clamp(b_rows);
      bc = clamp(b_cols);
      rows    = trans_a ? ac : ar;
      inner_a = trans_a ? ar : ac;
      inner_b = trans_b ? bc : br;
      cols    = trans_b ? br : bc;
    endfunction

    function void accept_item(op_e op, logic [IdxW-1:0] idx, logic [ElemW-1:0] ev,
                              logic [AccW-1:0] av);
      int unsigned rows, ia, ib, cols, ac, bc, o, ai, bi;
      longint      sum;
      elem_t       e;
      case (op)
        OP_LOAD_A: begin
          a_mem[idx] = ev;
          a_set[idx] = 1'b1;
        end
        OP_LOAD_B: begin
          b_mem[idx] = ev;
          b_set[idx] = 1'b1;
        end
        OP_LOAD_ACC: begin
          acc_mem[idx] = av;
          acc_set[idx] = 1'b1;
        end
        default: begin
          shape(rows, ia, ib, cols);
          if (ia != ib) begin
            // Inner dimensions disagree: one error element, accumulator untouched
            e.value = '0;
            e.index = '0;
            e.last  = 1'b1;
            e.err   = 1'b1;
            pending_elems.push_back(e);
          end else begin
            ac = clamp(a_cols);
            bc = clamp(b_cols);
            for (int i = 0; i < rows; i++) begin
              for (int k = 0; k < cols; k++) begin
                o = i * cols + k;
                if (clear_acc) sum = 0;
                else sum = acc_mem[o];
                // Saturate after every single addition, inner index ascending
                for (int j = 0; j < ia; j++) begin
                  ai  = trans_a ? (j * ac + i) : (i * ac + j);
                  bi  = trans_b ? (k * bc + j) : (j * bc + k);
                  sum = clip_acc(sum + longint'(a_mem[ai]) * longint'(b_mem[bi]));
                end
                acc_mem[o] = sum;
                acc_set[o] = 1'b1;
              end
            end
            for (int n = 0; n < rows * cols; n++) begin
              e.value = acc_mem[n];
              e.index = IdxW'(n);
              e.last  = (n + 1 == rows * cols);
              e.err   = 1'b0;
              pending_elems.push_back(e);
            end
          end
        end
      endcase
    endfunction

    function void compare_elem(logic [AccW-1:0] value, logic [IdxW-1:0] index,
                               logic last, logic err);
      elem_t want;
      if (pending_elems.size() == 0) begin
        $display("%0t: unexpected result out_value %0d out_index %0d", $time,
                 $signed(value), index);
        failures++;
        return;
      end
      want = pending_elems.pop_front();
      if (value !== want.value) begin
        $display("%0t: out_value expected %0d actual %0d", $time, $signed(want.value),
                 $signed(value));
        failures++;
      end
      if (index !== want.index) begin
        $display("%0t: out_index expected %0d actual %0d", $time, want.index, index);
        failures++;
      end
      if (last !== want.last) begin
        $display("%0t: is_last expected %0d actual %0d", $time, want.last, last);
        failures++;
      end
      if (err !== want.err) begin
        $display("%0t: dim_error expected %0d actual %0d", $time, want.err, err);
        failures++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [SDataW-1:0]  s_axis_tdata_i  = '0;  // elem_index, elem_value, acc_value, pad
  logic [OpW-1:0]     s_axis_tuser_i  = '0;  // op
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [MDataW-1:0]  m_axis_tdata_o;        // out_value, out_index, pad
  logic               m_axis_tlast_o;        // is_last
  logic               m_axis_tuser_o;        // dim_error
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i     = '0;
  logic [CfgDatW-1:0] cfg_data_i      = '0;

  gemm_predictor preds = new();
  bit            calm = 1'b0;       // no idling on either side while set
  int unsigned   items_sent = 0;
  int unsigned   quiet_cycles = 0;

  matrix_multiply_transpose_accumulate u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stall the result stream about 9 percent of the time, never while calm
  always @(posedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 9);
  end

  // Check every result transaction; end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        preds.compare_elem(m_axis_tdata_o[AccW-1:0], m_axis_tdata_o[AccW+IdxW-1:AccW],
                           m_axis_tlast_o, m_axis_tuser_o);
      end
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Operand values: mostly random, with the Q8.8 extremes mixed in
  function automatic logic [ElemW-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return ElemW'($urandom_range(0, 15)) - 16'd8;
      default: return ElemW'($urandom);
    endcase
  endfunction

  // Accumulator start values: near either rail often enough to saturate
  function automatic logic [AccW-1:0] rand_acc();
    case ($urandom_range(0, 7))
      0: return 40'h7f_ffff_0000 + AccW'($urandom_range(0, 65535));
      1: return 40'h80_0000_0000 + AccW'($urandom_range(0, 65535));
      2: return AccW'($urandom_range(0, 2047)) - 40'd1024;
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Dimension register value: mostly small, sometimes the largest or out of range
  function automatic logic [CountW-1:0] pick_count();
    case ($urandom_range(0, 19))
      0: return 4'd0;
      1: return CountW'($urandom_range(9, 15));
      2, 3: return 4'd8;
      default: return CountW'($urandom_range(1, 4));
    endcase
  endfunction

  // Present one input transaction, hold it until accepted, then predict it
  task automatic send_item(op_e op, logic [IdxW-1:0] idx, logic [ElemW-1:0] ev,
                           logic [AccW-1:0] av);
    if (!calm && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {2'b00, av, ev, idx};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    preds.accept_item(op, idx, ev, av);
    items_sent++;
  endtask

  // Load entries 0 .. count-1 of one store with fresh values
  task automatic load_store(op_e op, int unsigned count);
    for (int n = 0; n < count; n++) send_item(op, IdxW'(n), rand_elem(), rand_acc());
  endtask

  // Drop valid, drain all pending results, then let the block settle
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (preds.pending_elems.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    preds.set_register(idx, data);
  endtask

  // Write all seven registers; flag registers carry random upper bits
  task automatic write_config(logic [CountW-1:0] ar, logic [CountW-1:0] ac,
                              logic [CountW-1:0] br, logic [CountW-1:0] bc,
                              bit ta, bit tb, bit clr);
    write_reg(CFG_A_ROWS, ar);
    write_reg(CFG_A_COLS, ac);
    write_reg(CFG_B_ROWS, br);
    write_reg(CFG_B_COLS, bc);
    write_reg(CFG_TRANS_A, {3'($urandom_range(0, 7)), ta});
    write_reg(CFG_TRANS_B, {3'($urandom_range(0, 7)), tb});
    write_reg(CFG_CLEAR, {3'($urandom_range(0, 7)), clr});
    cfg_valid_i <= 1'b0;
  endtask

  // Issue a run; first fill any store entry it would read that was never loaded
  task automatic run_product();
    int unsigned rows, ia, ib, cols;
    preds.shape(rows, ia, ib, cols);
    if (ia == ib) begin
      for (int n = 0; n < preds.clamp(preds.a_rows) * preds.clamp(preds.a_cols); n++)
        if (!preds.a_set[n]) send_item(OP_LOAD_A, IdxW'(n), rand_elem(), rand_acc());
      for (int n = 0; n < preds.clamp(preds.b_rows) * preds.clamp(preds.b_cols); n++)
        if (!preds.b_set[n]) send_item(OP_LOAD_B, IdxW'(n), rand_elem(), rand_acc());
      if (!preds.clear_acc) begin
        for (int n = 0; n < rows * cols; n++)
          if (!preds.acc_set[n]) send_item(OP_LOAD_ACC, IdxW'(n), rand_elem(), rand_acc());
      end
    end
    send_item(OP_RUN, IdxW'($urandom_range(0, 63)), rand_elem(), rand_acc());
  endtask

  initial begin : stimulus
    logic [CountW-1:0] ar, ac, br, bc;
    bit                ta, tb, clr;
    int unsigned       inner;
    int unsigned       phase_no;

    phase_no = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset shape is 1x1 with clearing on
    send_item(OP_LOAD_A, 6'd0, 16'h8000, rand_acc());
    send_item(OP_LOAD_B, 6'd0, 16'h8000, rand_acc());
    send_item(OP_RUN, 6'd0, rand_elem(), rand_acc());   // most negative squared
    send_item(OP_LOAD_A, 6'd0, 16'h7fff, rand_acc());
    send_item(OP_RUN, 6'd63, rand_elem(), rand_acc());

    // Accumulate onto a start value near the top rail, then near the bottom one
    settle();
    write_config(4'd1, 4'd1, 4'd1, 4'd1, 1'b0, 1'b0, 1'b0);
    send_item(OP_LOAD_ACC, 6'd0, rand_elem(), 40'h7f_ffff_fff0);
    send_item(OP_LOAD_B, 6'd0, 16'h7fff, rand_acc());
    send_item(OP_RUN, 6'd0, rand_elem(), rand_acc());
    send_item(OP_LOAD_ACC, 6'd0, rand_elem(), 40'h80_0000_0010);
    send_item(OP_LOAD_A, 6'd0, 16'h8000, rand_acc());
    send_item(OP_RUN, 6'd0, rand_elem(), rand_acc());

    // Zero counts act as one, both transposes on
    settle();
    write_config(4'd0, 4'd0, 4'd0, 4'd0, 1'b1, 1'b1, 1'b1);
    send_item(OP_RUN, 6'd21, rand_elem(), rand_acc());

    // Inner dimensions disagree: single error element
    settle();
    write_config(4'd2, 4'd3, 4'd2, 4'd1, 1'b0, 1'b0, 1'b1);
    send_item(OP_RUN, 6'd42, rand_elem(), rand_acc());

    // Transposed 1x2 by 2x1, accumulating onto the earlier entry
    settle();
    write_config(4'd2, 4'd1, 4'd1, 4'd2, 1'b1, 1'b1, 1'b0);
    run_product();

    // Random phases: mostly full reloads then a run, with stray loads mixed in
    while (items_sent < 190) begin
      phase_no++;
      ar  = pick_count();
      ac  = pick_count();
      br  = pick_count();
      bc  = pick_count();
      ta  = $urandom_range(0, 1);
      tb  = $urandom_range(0, 1);
      clr = $urandom_range(0, 1);
      // Make the inner dimensions agree most of the time
      inner = ta ? preds.clamp(ar) : preds.clamp(ac);
      if ($urandom_range(0, 99) < 85) begin
        if (tb) bc = CountW'(inner);
        else br = CountW'(inner);
      end

      settle();
      calm = (phase_no >= 4 && phase_no < 8);
      write_config(ar, ac, br, bc, ta, tb, clr);

      if ($urandom_range(0, 3) != 0) load_store(OP_LOAD_A, preds.clamp(ar) * preds.clamp(ac));
      if ($urandom_range(0, 3) != 0) load_store(OP_LOAD_B, preds.clamp(br) * preds.clamp(bc));
      if (!clr && $urandom_range(0, 1) == 1) load_store(OP_LOAD_ACC, MaxDimDefault * 2);
      repeat ($urandom_range(0, 3)) begin
        send_item(op_e'($urandom_range(0, 2)), IdxW'($urandom_range(0, 63)), rand_elem(),
                  rand_acc());
      end
      run_product();
      if ($urandom_range(0, 2) == 0) run_product();
    end

    settle();
    if (preds.failures == 0 && preds.pending_elems.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/mmta_pkg.sv
sv/mmta_ram.sv
sv/mmta_mac.sv
sv/mmta_ctrl.sv
sv/matrix_multiply_transpose_accumulate.sv
bench/testbench.sv
